>>> rtl/cpi_pkg.sv
// ----------------------------------------------------------------------------
// Cascaded PI controller package
// Shared widths, register indexes, controller states, datapath command
// encodings and the fixed-point saturation helpers.
// ----------------------------------------------------------------------------
package cpi_pkg;

  localparam int DataW   = 32;
  localparam int ProdW   = 2 * DataW;
  localparam int QFrac   = 16;
  localparam int NumRegs = 7;
  localparam int RegIdxW = 3;

  // Configuration register indexes.
  localparam logic [RegIdxW-1:0] REG_SPEED_PROP   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_SPEED_INT    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_CURRENT_PROP = 3'd2;
  localparam logic [RegIdxW-1:0] REG_CURRENT_INT  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_EMF          = 3'd4;
  localparam logic [RegIdxW-1:0] REG_INV_PERIOD   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_HALF_PERIOD  = 3'd6;

  typedef logic signed [DataW-1:0] q_t;
  typedef logic signed [ProdW-1:0] prod_t;

  // Controller states, one per micro-step of a sample.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL_V,
    ST_V,
    ST_E,
    ST_MUL_A,
    ST_A,
    ST_SUM_A,
    ST_MUL_HA,
    ST_B,
    ST_MUL_PS,
    ST_IREF,
    ST_IE,
    ST_MUL_C,
    ST_C,
    ST_SUM_C,
    ST_MUL_HC,
    ST_D,
    ST_MUL_PC,
    ST_U,
    ST_MUL_EMF,
    ST_Y
  } state_t;

  // Operand sources for the adder and the multiplier data input.
  typedef enum logic [4:0] {
    OPD_ZERO,
    OPD_PROD,
    OPD_T,
    OPD_V,
    OPD_E,
    OPD_A,
    OPD_B,
    OPD_IE,
    OPD_C,
    OPD_D,
    OPD_POS,
    OPD_LAST_POS,
    OPD_SPEED_CMD,
    OPD_CURRENT,
    OPD_LAST_SPEED_IN,
    OPD_SPEED_INT,
    OPD_LAST_CURRENT_IN,
    OPD_CURRENT_INT
  } opnd_t;

  // Destination of the saturated adder result.
  typedef enum logic [3:0] {
    DST_NONE,
    DST_T,
    DST_V,
    DST_E,
    DST_A,
    DST_B,
    DST_IE,
    DST_C,
    DST_D
  } dst_t;

  // Command word from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                mul_en;
    logic [RegIdxW-1:0]  mul_gain;
    opnd_t               mul_opnd;
    opnd_t               alu_a;
    opnd_t               alu_b;
    logic                alu_sub;
    dst_t                alu_dst;
    logic                commit;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

  // Saturate a 33-bit exact sum or difference to 32 bits.
  function automatic q_t sat_sum(input logic signed [DataW:0] x);
    q_t r;
    if (x[DataW] != x[DataW-1]) begin
      r = x[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      r = x[DataW-1:0];
    end
    return r;
  endfunction

  // Floor-shift a full product by the fraction width and saturate.
  function automatic q_t sat_prod(input prod_t p);
    logic signed [ProdW-QFrac-1:0] s;
    q_t r;
    s = p[ProdW-1:QFrac];
    if (s[ProdW-QFrac-1:DataW-1] != {(ProdW-QFrac-DataW+1){s[DataW-1]}}) begin
      r = s[ProdW-QFrac-1] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      r = s[DataW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/cpi_ifs.sv
// ----------------------------------------------------------------------------
// Cascaded PI controller channel interfaces
// Valid/ready channels for the measurement beat and the drive beat.
// ----------------------------------------------------------------------------
interface cpi_meas_if;
  logic          valid;
  logic          ready;
  cpi_pkg::q_t   armature_current;
  cpi_pkg::q_t   rotor_position;
  cpi_pkg::q_t   speed_command;

  modport source (output valid, output armature_current, output rotor_position,
                  output speed_command, input ready);
  modport sink (input valid, input armature_current, input rotor_position,
                input speed_command, output ready);
endinterface

interface cpi_drive_if;
  logic          valid;
  logic          ready;
  cpi_pkg::q_t   drive_voltage;

  modport source (output valid, output drive_voltage, input ready);
  modport sink (input valid, input drive_voltage, output ready);
endinterface

>>> rtl/cpi_controller.sv
// ----------------------------------------------------------------------------
// Cascaded PI controller sequencer
// Steps the datapath through the micro-operations of one sample.
// ----------------------------------------------------------------------------
module cpi_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              meas_valid,
  output logic              meas_ready,
  input  cpi_pkg::status_t  status,
  output cpi_pkg::cmd_t     cmd
);

  cpi_pkg::state_t state;
  cpi_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cpi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: a fixed walk, waiting only for a beat and for the output slot.
  always_comb begin
    state_next = state;
    case (state)
      cpi_pkg::ST_IDLE:    if (meas_valid) state_next = cpi_pkg::ST_DIFF;
      cpi_pkg::ST_DIFF:    state_next = cpi_pkg::ST_MUL_V;
      cpi_pkg::ST_MUL_V:   state_next = cpi_pkg::ST_V;
      cpi_pkg::ST_V:       state_next = cpi_pkg::ST_E;
      cpi_pkg::ST_E:       state_next = cpi_pkg::ST_MUL_A;
      cpi_pkg::ST_MUL_A:   state_next = cpi_pkg::ST_A;
      cpi_pkg::ST_A:       state_next = cpi_pkg::ST_SUM_A;
      cpi_pkg::ST_SUM_A:   state_next = cpi_pkg::ST_MUL_HA;
      cpi_pkg::ST_MUL_HA:  state_next = cpi_pkg::ST_B;
      cpi_pkg::ST_B:       state_next = cpi_pkg::ST_MUL_PS;
      cpi_pkg::ST_MUL_PS:  state_next = cpi_pkg::ST_IREF;
      cpi_pkg::ST_IREF:    state_next = cpi_pkg::ST_IE;
      cpi_pkg::ST_IE:      state_next = cpi_pkg::ST_MUL_C;
      cpi_pkg::ST_MUL_C:   state_next = cpi_pkg::ST_C;
      cpi_pkg::ST_C:       state_next = cpi_pkg::ST_SUM_C;
      cpi_pkg::ST_SUM_C:   state_next = cpi_pkg::ST_MUL_HC;
      cpi_pkg::ST_MUL_HC:  state_next = cpi_pkg::ST_D;
      cpi_pkg::ST_D:       state_next = cpi_pkg::ST_MUL_PC;
      cpi_pkg::ST_MUL_PC:  state_next = cpi_pkg::ST_U;
      cpi_pkg::ST_U:       state_next = cpi_pkg::ST_MUL_EMF;
      cpi_pkg::ST_MUL_EMF: state_next = cpi_pkg::ST_Y;
      cpi_pkg::ST_Y:       if (status.out_free) state_next = cpi_pkg::ST_IDLE;
      default:             state_next = cpi_pkg::ST_IDLE;
    endcase
  end

  // Command decode for each state.
  always_comb begin
    meas_ready   = 1'b0;
    cmd          = '0;
    cmd.mul_gain = cpi_pkg::REG_SPEED_PROP;
    cmd.mul_opnd = cpi_pkg::OPD_ZERO;
    cmd.alu_a    = cpi_pkg::OPD_ZERO;
    cmd.alu_b    = cpi_pkg::OPD_ZERO;
    cmd.alu_dst  = cpi_pkg::DST_NONE;
    case (state)
      cpi_pkg::ST_IDLE: begin
        meas_ready = 1'b1;
        cmd.load   = meas_valid;
      end
      cpi_pkg::ST_DIFF: begin
        cmd.alu_a   = cpi_pkg::OPD_POS;
        cmd.alu_b   = cpi_pkg::OPD_LAST_POS;
        cmd.alu_sub = 1'b1;
        cmd.alu_dst = cpi_pkg::DST_T;
      end
      cpi_pkg::ST_MUL_V: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = cpi_pkg::REG_INV_PERIOD;
        cmd.mul_opnd = cpi_pkg::OPD_T;
      end
      cpi_pkg::ST_V: begin
        cmd.alu_b   = cpi_pkg::OPD_PROD;
        cmd.alu_dst = cpi_pkg::DST_V;
      end
      cpi_pkg::ST_E: begin
        cmd.alu_a   = cpi_pkg::OPD_SPEED_CMD;
        cmd.alu_b   = cpi_pkg::OPD_V;
        cmd.alu_sub = 1'b1;
        cmd.alu_dst = cpi_pkg::DST_E;
      end
      cpi_pkg::ST_MUL_A: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = cpi_pkg::REG_SPEED_INT;
        cmd.mul_opnd = cpi_pkg::OPD_E;
      end
      cpi_pkg::ST_A: begin
        cmd.alu_b   = cpi_pkg::OPD_PROD;
        cmd.alu_dst = cpi_pkg::DST_A;
      end
      cpi_pkg::ST_SUM_A: begin
        cmd.alu_a   = cpi_pkg::OPD_LAST_SPEED_IN;
        cmd.alu_b   = cpi_pkg::OPD_A;
        cmd.alu_dst = cpi_pkg::DST_T;
      end
      cpi_pkg::ST_MUL_HA: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = cpi_pkg::REG_HALF_PERIOD;
        cmd.mul_opnd = cpi_pkg::OPD_T;
      end
      cpi_pkg::ST_B: begin
        cmd.alu_a   = cpi_pkg::OPD_SPEED_INT;
        cmd.alu_b   = cpi_pkg::OPD_PROD;
        cmd.alu_dst = cpi_pkg::DST_B;
      end
      cpi_pkg::ST_MUL_PS: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = cpi_pkg::REG_SPEED_PROP;
        cmd.mul_opnd = cpi_pkg::OPD_E;
      end
      cpi_pkg::ST_IREF: begin
        cmd.alu_a   = cpi_pkg::OPD_PROD;
        cmd.alu_b   = cpi_pkg::OPD_B;
        cmd.alu_dst = cpi_pkg::DST_T;
      end
      cpi_pkg::ST_IE: begin
        cmd.alu_a   = cpi_pkg::OPD_T;
        cmd.alu_b   = cpi_pkg::OPD_CURRENT;
        cmd.alu_sub = 1'b1;
        cmd.alu_dst = cpi_pkg::DST_IE;
      end
      cpi_pkg::ST_MUL_C: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = cpi_pkg::REG_CURRENT_INT;
        cmd.mul_opnd = cpi_pkg::OPD_IE;
      end
      cpi_pkg::ST_C: begin
        cmd.alu_b   = cpi_pkg::OPD_PROD;
        cmd.alu_dst = cpi_pkg::DST_C;
      end
      cpi_pkg::ST_SUM_C: begin
        cmd.alu_a   = cpi_pkg::OPD_LAST_CURRENT_IN;
        cmd.alu_b   = cpi_pkg::OPD_C;
        cmd.alu_dst = cpi_pkg::DST_T;
      end
      cpi_pkg::ST_MUL_HC: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = cpi_pkg::REG_HALF_PERIOD;
        cmd.mul_opnd = cpi_pkg::OPD_T;
      end
      cpi_pkg::ST_D: begin
        cmd.alu_a   = cpi_pkg::OPD_CURRENT_INT;
        cmd.alu_b   = cpi_pkg::OPD_PROD;
        cmd.alu_dst = cpi_pkg::DST_D;
      end
      cpi_pkg::ST_MUL_PC: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = cpi_pkg::REG_CURRENT_PROP;
        cmd.mul_opnd = cpi_pkg::OPD_IE;
      end
      cpi_pkg::ST_U: begin
        cmd.alu_a   = cpi_pkg::OPD_PROD;
        cmd.alu_b   = cpi_pkg::OPD_D;
        cmd.alu_dst = cpi_pkg::DST_T;
      end
      cpi_pkg::ST_MUL_EMF: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_gain = cpi_pkg::REG_EMF;
        cmd.mul_opnd = cpi_pkg::OPD_V;
      end
      cpi_pkg::ST_Y: begin
        // Final sum goes straight to the output register.
        cmd.alu_a  = cpi_pkg::OPD_T;
        cmd.alu_b  = cpi_pkg::OPD_PROD;
        cmd.commit = status.out_free;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/cpi_datapath.sv
// ----------------------------------------------------------------------------
// Cascaded PI controller datapath
// Gain registers, loop state, one shared multiplier with a product register,
// a saturating adder and the output register.
// ----------------------------------------------------------------------------
module cpi_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cpi_pkg::RegIdxW-1:0]  cfg_index,
  input  logic [cpi_pkg::DataW-1:0]    cfg_data,
  input  cpi_pkg::q_t                  armature_current,
  input  cpi_pkg::q_t                  rotor_position,
  input  cpi_pkg::q_t                  speed_command,
  input  cpi_pkg::cmd_t                cmd,
  output cpi_pkg::status_t             status,
  input  logic                         out_ready,
  output logic                         out_valid,
  output cpi_pkg::q_t                  drive_voltage
);

  // Gain registers.
  cpi_pkg::q_t gains [cpi_pkg::NumRegs];

  // Loop state kept across samples.
  cpi_pkg::q_t last_pos;
  cpi_pkg::q_t last_speed_in;
  cpi_pkg::q_t speed_int;
  cpi_pkg::q_t last_current_in;
  cpi_pkg::q_t current_int;

  // Latched sample and working values.
  cpi_pkg::q_t pos;
  cpi_pkg::q_t spd_cmd;
  cpi_pkg::q_t cur;
  cpi_pkg::q_t t;
  cpi_pkg::q_t v;
  cpi_pkg::q_t e;
  cpi_pkg::q_t a;
  cpi_pkg::q_t b;
  cpi_pkg::q_t ie;
  cpi_pkg::q_t c;
  cpi_pkg::q_t d;
  cpi_pkg::prod_t prod;

  cpi_pkg::q_t prod_q;
  cpi_pkg::q_t alu_a;
  cpi_pkg::q_t alu_b;
  cpi_pkg::q_t alu_res;
  cpi_pkg::q_t mul_x;
  cpi_pkg::q_t mul_y;
  logic signed [cpi_pkg::DataW:0] alu_sum;

  // Operand select shared by the adder inputs and the multiplier.
  function automatic cpi_pkg::q_t pick(input cpi_pkg::opnd_t sel,
                                       input cpi_pkg::q_t p_q);
    cpi_pkg::q_t r;
    case (sel)
      cpi_pkg::OPD_ZERO:            r = '0;
      cpi_pkg::OPD_PROD:            r = p_q;
      cpi_pkg::OPD_T:               r = t;
      cpi_pkg::OPD_V:               r = v;
      cpi_pkg::OPD_E:               r = e;
      cpi_pkg::OPD_A:               r = a;
      cpi_pkg::OPD_B:               r = b;
      cpi_pkg::OPD_IE:              r = ie;
      cpi_pkg::OPD_C:               r = c;
      cpi_pkg::OPD_D:               r = d;
      cpi_pkg::OPD_POS:             r = pos;
      cpi_pkg::OPD_LAST_POS:        r = last_pos;
      cpi_pkg::OPD_SPEED_CMD:       r = spd_cmd;
      cpi_pkg::OPD_CURRENT:         r = cur;
      cpi_pkg::OPD_LAST_SPEED_IN:   r = last_speed_in;
      cpi_pkg::OPD_SPEED_INT:       r = speed_int;
      cpi_pkg::OPD_LAST_CURRENT_IN: r = last_current_in;
      cpi_pkg::OPD_CURRENT_INT:     r = current_int;
      default:                      r = '0;
    endcase
    return r;
  endfunction

  // Scaled, saturated product and the saturating adder.
  always_comb begin
    prod_q  = cpi_pkg::sat_prod(prod);
    alu_a   = pick(cmd.alu_a, prod_q);
    alu_b   = pick(cmd.alu_b, prod_q);
    alu_sum = cmd.alu_sub ? ({alu_a[cpi_pkg::DataW-1], alu_a} - {alu_b[cpi_pkg::DataW-1], alu_b})
                          : ({alu_a[cpi_pkg::DataW-1], alu_a} + {alu_b[cpi_pkg::DataW-1], alu_b});
    alu_res = cpi_pkg::sat_sum(alu_sum);
    mul_x   = gains[cmd.mul_gain];
    mul_y   = pick(cmd.mul_opnd, prod_q);
  end

  // Gain register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cpi_pkg::NumRegs; i++) begin
        gains[i] <= '0;
      end
    end else if (cfg_we && (int'(cfg_index) < cpi_pkg::NumRegs)) begin
      gains[cfg_index] <= cfg_data;
    end
  end

  // Sample latch, multiplier and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos     <= rotor_position;
      spd_cmd <= speed_command;
      cur     <= armature_current;
    end
    if (cmd.mul_en) begin
      prod <= mul_x * mul_y;
    end
    case (cmd.alu_dst)
      cpi_pkg::DST_T:  t  <= alu_res;
      cpi_pkg::DST_V:  v  <= alu_res;
      cpi_pkg::DST_E:  e  <= alu_res;
      cpi_pkg::DST_A:  a  <= alu_res;
      cpi_pkg::DST_B:  b  <= alu_res;
      cpi_pkg::DST_IE: ie <= alu_res;
      cpi_pkg::DST_C:  c  <= alu_res;
      cpi_pkg::DST_D:  d  <= alu_res;
      default: ;
    endcase
    if (cmd.commit) begin
      drive_voltage <= alu_res;
    end
  end

  // Loop state update at the end of a sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pos        <= '0;
      last_speed_in   <= '0;
      speed_int       <= '0;
      last_current_in <= '0;
      current_int     <= '0;
    end else if (cmd.commit) begin
      last_pos        <= pos;
      last_speed_in   <= a;
      speed_int       <= b;
      last_current_in <= c;
      current_int     <= d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

>>> rtl/cascaded_pi_motor_speed_current_core.sv
// ----------------------------------------------------------------------------
// Cascaded PI speed and current controller
// Each measurement beat yields one drive beat. The work runs through one
// shared 32x32 multiplier: eight products and the saturating adds around them,
// from taking a beat in the idle state to loading the output register in the
// last state, which waits while a drive beat is still held; it then returns
// to idle for the next beat. The output register lets the next sample start
// while a drive beat is still waiting. Gains are to be written through the
// configuration port while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module cascaded_pi_motor_speed_current_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cpi_pkg::RegIdxW-1:0]  cfg_index,
  input  logic [cpi_pkg::DataW-1:0]    cfg_data,
  cpi_meas_if.sink                     meas,
  cpi_drive_if.source                  drive
);

  cpi_pkg::cmd_t    cmd;
  cpi_pkg::status_t status;

  // Sequencer.
  cpi_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas.valid),
    .meas_ready (meas.ready),
    .status     (status),
    .cmd        (cmd)
  );

  // Arithmetic and state.
  cpi_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .armature_current (meas.armature_current),
    .rotor_position   (meas.rotor_position),
    .speed_command    (meas.speed_command),
    .cmd              (cmd),
    .status           (status),
    .out_ready        (drive.ready),
    .out_valid        (drive.valid),
    .drive_voltage    (drive.drive_voltage)
  );

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Cascaded PI speed and current controller testbench
// Drives measurement beats with random gaps and stalls on the drive side.
// Gains are reloaded between phases while the block is idle. A bit-exact
// model of the two PI loops predicts each drive voltage, and every drive
// beat is compared in order with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam cpi_pkg::q_t QHi = 32'sh7fff_ffff;
  localparam cpi_pkg::q_t QLo = 32'sh8000_0000;
  localparam cpi_pkg::q_t QOne = 32'sh0001_0000;
  localparam logic [cpi_pkg::RegIdxW-1:0] REG_NONE = cpi_pkg::RegIdxW'(cpi_pkg::NumRegs);
  localparam int QuietLimit = 1000;
  localparam int SettleCycles = 30;
  localparam int NumPhases = 10;
  localparam int PhaseItems = 68;

  typedef enum int {GAIN_TYPICAL, GAIN_CORNER, GAIN_WILD} gain_style_t;

  // Bit-exact model of the controller and the queue of voltages it predicts.
  class pi_voltage_checker;
    cpi_pkg::q_t gain [cpi_pkg::NumRegs];
    cpi_pkg::q_t last_pos;
    cpi_pkg::q_t last_speed_in;
    cpi_pkg::q_t speed_acc;
    cpi_pkg::q_t last_current_in;
    cpi_pkg::q_t current_acc;
    cpi_pkg::q_t voltage_due [$];
    int unsigned faults;

    function new();
      foreach (gain[i]) gain[i] = '0;
      last_pos = '0;
      last_speed_in = '0;
      speed_acc = '0;
      last_current_in = '0;
      current_acc = '0;
      faults = 0;
    endfunction

    // Clamp an exact value to the signed 32-bit range.
    static function cpi_pkg::q_t clip(longint x);
      if (x > 64'sd2147483647) return QHi;
      if (x < -64'sd2147483648) return QLo;
      return cpi_pkg::q_t'(x);
    endfunction

    static function cpi_pkg::q_t q_add(cpi_pkg::q_t a, cpi_pkg::q_t b);
      return clip(longint'(a) + longint'(b));
    endfunction

    static function cpi_pkg::q_t q_sub(cpi_pkg::q_t a, cpi_pkg::q_t b);
      return clip(longint'(a) - longint'(b));
    endfunction

    // Full product, floor shift by the fraction width, then clamp.
    static function cpi_pkg::q_t q_mul(cpi_pkg::q_t a, cpi_pkg::q_t b);
      longint p;
      p = longint'(a) * longint'(b);
      return clip(p >>> cpi_pkg::QFrac);
    endfunction

    function void set_gain(logic [cpi_pkg::RegIdxW-1:0] idx, cpi_pkg::q_t value);
      if (idx < cpi_pkg::NumRegs) gain[idx] = value;
    endfunction

    // Run one sample through both loops and queue the drive voltage.
    function void note_sample(cpi_pkg::q_t cur, cpi_pkg::q_t pos, cpi_pkg::q_t cmd);
      cpi_pkg::q_t spd, err, a, b, iref, ie, c, d, u;
      spd = q_mul(gain[cpi_pkg::REG_INV_PERIOD], q_sub(pos, last_pos));
      err = q_sub(cmd, spd);
      a = q_mul(gain[cpi_pkg::REG_SPEED_INT], err);
      b = q_add(speed_acc,
                q_mul(gain[cpi_pkg::REG_HALF_PERIOD], q_add(last_speed_in, a)));
      iref = q_add(q_mul(gain[cpi_pkg::REG_SPEED_PROP], err), b);
      ie = q_sub(iref, cur);
      c = q_mul(gain[cpi_pkg::REG_CURRENT_INT], ie);
      d = q_add(current_acc,
                q_mul(gain[cpi_pkg::REG_HALF_PERIOD], q_add(last_current_in, c)));
      u = q_add(q_mul(gain[cpi_pkg::REG_CURRENT_PROP], ie), d);
      voltage_due.push_back(q_add(u, q_mul(gain[cpi_pkg::REG_EMF], spd)));
      last_pos = pos;
      last_speed_in = a;
      speed_acc = b;
      last_current_in = c;
      current_acc = d;
    endfunction

    function void check_voltage(cpi_pkg::q_t got);
      cpi_pkg::q_t want;
      if (voltage_due.size() == 0) begin
        $error("drive_voltage: expected none, actual %0d", got);
        faults++;
        return;
      end
      want = voltage_due.pop_front();
      if (got !== want) begin
        $error("drive_voltage: expected %0d, actual %0d", want, got);
        faults++;
      end
    endfunction

    function int pending();
      return voltage_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [cpi_pkg::RegIdxW-1:0] cfg_index;
  logic [cpi_pkg::DataW-1:0] cfg_data;
  logic calm = 1'b0;
  int unsigned idle_pct = 15;
  int unsigned quiet_cycles = 0;
  pi_voltage_checker board;

  cpi_meas_if meas_ch();
  cpi_drive_if drive_ch();

  cascaded_pi_motor_speed_current_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .meas(meas_ch),
    .drive(drive_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Typical gains of a small drive sampled at 1 kHz.
  function automatic cpi_pkg::q_t nominal_gain(logic [cpi_pkg::RegIdxW-1:0] idx);
    case (idx)
      cpi_pkg::REG_SPEED_PROP: return 32'sd131072;
      cpi_pkg::REG_SPEED_INT: return 32'sd655360;
      cpi_pkg::REG_CURRENT_PROP: return 32'sd98304;
      cpi_pkg::REG_CURRENT_INT: return 32'sd3276800;
      cpi_pkg::REG_EMF: return 32'sd3277;
      cpi_pkg::REG_INV_PERIOD: return 32'sd65536000;
      cpi_pkg::REG_HALF_PERIOD: return 32'sd33;
      default: return '0;
    endcase
  endfunction

  function automatic cpi_pkg::q_t rand_gain(gain_style_t style, cpi_pkg::q_t nominal);
    case (style)
      GAIN_TYPICAL: return nominal / 2 + cpi_pkg::q_t'($urandom_range(nominal));
      GAIN_CORNER: begin
        case ($urandom_range(4))
          0: return QHi;
          1: return QLo;
          2: return '0;
          3: return -1;
          default: return QOne;
        endcase
      end
      default: return cpi_pkg::q_t'($urandom());
    endcase
  endfunction

  // Mostly values within +/- span, sometimes any pattern or a limit.
  function automatic cpi_pkg::q_t rand_q(int unsigned span);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) return ($urandom_range(1) != 0) ? QHi : QLo;
    if (pick < 20) return cpi_pkg::q_t'($urandom());
    return cpi_pkg::q_t'(int'($urandom_range(2 * span)) - int'(span));
  endfunction

  task automatic write_reg(input logic [cpi_pkg::RegIdxW-1:0] idx, input cpi_pkg::q_t value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    board.set_gain(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one measurement beat, possibly after a gap, and wait for it to go in.
  task automatic send(input cpi_pkg::q_t cur, input cpi_pkg::q_t pos, input cpi_pkg::q_t cmd);
    if (!calm && $urandom_range(99) < idle_pct) begin
      meas_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    meas_ch.valid <= 1'b1;
    meas_ch.armature_current <= cur;
    meas_ch.rotor_position <= pos;
    meas_ch.speed_command <= cmd;
    do @(posedge clk); while (meas_ch.ready !== 1'b1);
    board.note_sample(cur, pos, cmd);
  endtask

  // Hold off new beats until every predicted drive beat has come out.
  task automatic wait_drained();
    meas_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Drive side stalls in random bursts.
  initial begin
    drive_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(99) < idle_pct) begin
        drive_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      drive_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Check every drive beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst === 1'b0 && drive_ch.valid === 1'b1 && drive_ch.ready === 1'b1) begin
      board.check_voltage(drive_ch.drive_voltage);
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if ((meas_ch.valid === 1'b1 && meas_ch.ready === 1'b1) ||
        (drive_ch.valid === 1'b1 && drive_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("cascaded_pi_motor_speed_current_core: mismatch");
      $finish;
    end
  end

  initial begin
    int ph;
    int k;
    int ri;
    cpi_pkg::q_t pos_walk;
    cpi_pkg::q_t cmd_hold;
    gain_style_t style;
    board = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    meas_ch.valid <= 1'b0;
    meas_ch.armature_current <= '0;
    meas_ch.rotor_position <= '0;
    meas_ch.speed_command <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Only some gains loaded; the integral gains and half period stay at zero.
    write_reg(cpi_pkg::REG_INV_PERIOD, nominal_gain(cpi_pkg::REG_INV_PERIOD));
    write_reg(cpi_pkg::REG_EMF, nominal_gain(cpi_pkg::REG_EMF));
    write_reg(cpi_pkg::REG_CURRENT_PROP, nominal_gain(cpi_pkg::REG_CURRENT_PROP));

    // First sample differentiates against a zero previous position.
    send('0, QOne, '0);
    send('0, QOne, '0);
    send(QHi, QHi, QHi);
    send(QLo, QLo, QLo);
    send('0, QHi, '0);
    send(-1, -1, -1);
    send(1, '0, 1);
    send('0, '0, '0);

    // Typical gains on every register; a write past the last index is dropped.
    wait_drained();
    for (ri = 0; ri < cpi_pkg::NumRegs; ri++) begin
      write_reg(cpi_pkg::RegIdxW'(ri), nominal_gain(cpi_pkg::RegIdxW'(ri)));
    end
    write_reg(REG_NONE, cpi_pkg::q_t'($urandom()));
    send(32'sd131072, 32'sd655, 32'sd655360);
    send(32'sd131072, 32'sd1310, 32'sd655360);
    send(32'sd131072, 32'sd1965, 32'sd655360);
    send(32'sd131072, 32'sd2620, 32'sd655360);
    send(QLo, 32'sd3275, QHi);
    send(QHi, 32'sd3930, QLo);

    // All gains at the positive limit, then at the negative limit.
    wait_drained();
    for (ri = 0; ri < cpi_pkg::NumRegs; ri++) write_reg(cpi_pkg::RegIdxW'(ri), QHi);
    send(1, 1, 1);
    send(QHi, QLo, QHi);
    send(-1, '0, QLo);
    send('0, '0, '0);
    wait_drained();
    for (ri = 0; ri < cpi_pkg::NumRegs; ri++) write_reg(cpi_pkg::RegIdxW'(ri), QLo);
    send(1, -1, 1);
    send(QLo, QHi, QLo);
    send(QHi, '0, '0);
    send('0, '0, '0);

    // Random phases: new gains each time, position as a slow walk.
    pos_walk = '0;
    cmd_hold = '0;
    for (ph = 0; ph < NumPhases; ph++) begin
      wait_drained();
      calm = (ph == NumPhases - 1);
      idle_pct = calm ? 0 : 15 * $urandom_range(2);
      k = $urandom_range(9);
      if (calm || k < 6) begin
        style = GAIN_TYPICAL;
      end else if (k < 8) begin
        style = GAIN_CORNER;
      end else begin
        style = GAIN_WILD;
      end
      for (ri = 0; ri < cpi_pkg::NumRegs; ri++) begin
        write_reg(cpi_pkg::RegIdxW'(ri), rand_gain(style, nominal_gain(cpi_pkg::RegIdxW'(ri))));
      end
      if ($urandom_range(3) == 0) write_reg(REG_NONE, cpi_pkg::q_t'($urandom()));
      for (k = 0; k < PhaseItems; k++) begin
        // Once mid-run the sender waits for the pipeline to empty.
        if (ph == 4 && k == PhaseItems / 2) wait_drained();
        if ($urandom_range(9) == 0) begin
          pos_walk = cpi_pkg::q_t'($urandom());
        end else begin
          pos_walk = pos_walk + cpi_pkg::q_t'(int'($urandom_range(2622)) - 1311);
        end
        if ($urandom_range(9) == 0) cmd_hold = rand_q(1310720);
        send(rand_q(655360), pos_walk, cmd_hold);
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("cascaded_pi_motor_speed_current_core: match");
    end else begin
      $display("cascaded_pi_motor_speed_current_core: mismatch");
    end
    $finish;
  end

endmodule
